// ===== hw/rtl/pta_pkg.sv =====
// shared types and constants for the point-to-angle unit
// octant codes, pipeline tag, field widths and the arctangent table entry function
// no dependencies
`default_nettype none

package pta_pkg;

  localparam int NUM_W     = 32;
  localparam int NUM_SHIFT = 3;
  localparam int DEN_SHIFT = 8;
  localparam int DEN_W     = NUM_W - DEN_SHIFT;
  localparam int SMALL_DEN = 512;

  localparam logic [31:0] ANG_90  = 32'h4000_0000;
  localparam logic [31:0] ANG_180 = 32'h8000_0000;
  localparam logic [31:0] ANG_270 = 32'hC000_0000;

  localparam real PI          = 3.14159265358979323846;
  localparam real ANGLE_SCALE = 4294967296.0 / (2.0 * PI);

  // encoding is {x negative, y negative, |x| > |y|}
  typedef enum logic [2:0] {
    OCT_NNE = 3'b000,
    OCT_ENE = 3'b001,
    OCT_SSE = 3'b010,
    OCT_ESE = 3'b011,
    OCT_NNW = 3'b100,
    OCT_WNW = 3'b101,
    OCT_SSW = 3'b110,
    OCT_WSW = 3'b111
  } octant_t;

  typedef struct packed {
    logic    zero;
    octant_t oct;
  } tag_t;

  // round(atan(idx * inv_steps) * 2^32 / (2*pi)), evaluated at elaboration
  function automatic logic [31:0] atan_entry(input int idx, input real inv_steps);
    real    a;
    real    v;
    longint r;
    a = $atan(real'(idx) * inv_steps);
    v = a * ANGLE_SCALE;
    r = longint'($floor(v + 0.5));
    return r[31:0];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/pta_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`default_nettype none

module pta_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2049
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== hw/rtl/pta_div.sv =====
// pipelined restoring divider for the slope index, one quotient bit per stage
// depends on pta_pkg for operand widths
`default_nettype none

module pta_div #(
  parameter int QB    = 12,
  parameter int TAG_W = 4
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  input  wire logic [pta_pkg::NUM_W-1:0] in_num,
  input  wire logic [pta_pkg::DEN_W-1:0] in_den,
  input  wire logic                    in_force,
  input  wire logic [TAG_W-1:0]        in_tag,
  output logic                         out_valid,
  output logic      [QB-1:0]           out_quo,
  output logic                         out_sat,
  output logic      [TAG_W-1:0]        out_tag
);

  localparam int WW = pta_pkg::DEN_W + QB;

  logic                       v_r   [QB+1];
  logic [WW-1:0]              rem_r [QB+1];
  logic [pta_pkg::DEN_W-1:0]  den_r [QB+1];
  logic [QB-1:0]              quo_r [QB+1];
  logic                       sat_r [QB+1];
  logic [TAG_W-1:0]           tag_r [QB+1];

  // entry stage: a quotient too large for QB bits, or in_force, means saturation
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    rem_r[0] <= WW'(in_num);
    den_r[0] <= in_den;
    quo_r[0] <= '0;
    sat_r[0] <= in_force || (WW'(in_num) >= (WW'(in_den) << QB));
    tag_r[0] <= in_tag;
  end

  for (genvar j = 1; j <= QB; j++) begin : g_step
    localparam int K = QB - j;
    logic [WW-1:0] sub_w;
    logic          ge_w;
    logic [WW-1:0] rem_nxt;
    logic [QB-1:0] quo_nxt;

    always_comb begin
      sub_w   = WW'(den_r[j-1]) << K;
      ge_w    = rem_r[j-1] >= sub_w;
      rem_nxt = ge_w ? (rem_r[j-1] - sub_w) : rem_r[j-1];
      quo_nxt = quo_r[j-1];
      quo_nxt[K] = ge_w;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else begin
        v_r[j] <= v_r[j-1];
      end
    end

    always_ff @(posedge clk) begin
      rem_r[j] <= rem_nxt;
      den_r[j] <= den_r[j-1];
      quo_r[j] <= quo_nxt;
      sat_r[j] <= sat_r[j-1];
      tag_r[j] <= tag_r[j-1];
    end
  end

  assign out_valid = v_r[QB];
  assign out_quo   = quo_r[QB];
  assign out_sat   = sat_r[QB];
  assign out_tag   = tag_r[QB];

endmodule

`default_nettype wire

// ===== hw/rtl/point_to_angle_octant_atan.sv =====
// point-to-angle unit top level: offset, octant select, slope divider, arctangent table
// depends on pta_pkg, pta_div and pta_ram
//
// Gives the 32-bit binary angle (full turn = 2^32, 0 = east) of a point seen from a
// view position. One item is taken per cycle whenever busy is low; each result
// appears on out_angle with out_valid high for exactly one cycle, in order.
// The slope divider resolves one quotient bit per stage.
// After reset the unit loads its arctangent table, one entry per cycle, and holds
// busy high until the last entry is written. The receiver cannot stall the result stream.
`default_nettype none

module point_to_angle_octant_atan #(
  parameter int SLOPE_STEPS = 2048
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [31:0] in_point_x,
  input  wire logic signed [31:0] in_point_y,
  input  wire logic signed [31:0] in_view_x,
  input  wire logic signed [31:0] in_view_y,
  output logic                    out_valid,
  output logic             [31:0] out_angle
);

  localparam int  AW        = $clog2(SLOPE_STEPS + 1);
  localparam int  LAT       = AW + 7;
  localparam int  TAG_W     = $bits(pta_pkg::tag_t);
  localparam real INV_STEPS = 1.0 / SLOPE_STEPS;

  // ---------------------------------------------------------------- table load
  logic [31:0]   rom_tbl [SLOPE_STEPS+1];
  logic [AW-1:0] fill_cnt_r;
  logic [AW-1:0] fill_cnt_nxt;
  logic          fill_act_r;
  logic          fill_act_nxt;

  for (genvar g = 0; g <= SLOPE_STEPS; g++) begin : g_tbl
    assign rom_tbl[g] = pta_pkg::atan_entry(g, INV_STEPS);
  end

  always_comb begin
    fill_cnt_nxt = fill_cnt_r;
    fill_act_nxt = fill_act_r;
    if (fill_act_r) begin
      if (fill_cnt_r == AW'(SLOPE_STEPS)) begin
        fill_act_nxt = 1'b0;
      end else begin
        fill_cnt_nxt = fill_cnt_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_cnt_r <= '0;
      fill_act_r <= 1'b1;
    end else begin
      fill_cnt_r <= fill_cnt_nxt;
      fill_act_r <= fill_act_nxt;
    end
  end

  assign busy = fill_act_r;

  logic in_acc;
  assign in_acc = start && !busy;

  // ---------------------------------------------------------------- offsets
  logic        v1_r;
  logic [31:0] dx_r;
  logic [31:0] dy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    dx_r <= 32'(in_point_x) - 32'(in_view_x);
    dy_r <= 32'(in_point_y) - 32'(in_view_y);
  end

  // ---------------------------------------------------------------- magnitudes
  logic        v2_r;
  logic [31:0] ax_r;
  logic [31:0] ay_r;
  logic        xn_r;
  logic        yn_r;
  logic        zero2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  // most negative offset stays negative after negation, as in the compare below
  always_ff @(posedge clk) begin
    ax_r    <= dx_r[31] ? (32'd0 - dx_r) : dx_r;
    ay_r    <= dy_r[31] ? (32'd0 - dy_r) : dy_r;
    xn_r    <= dx_r[31];
    yn_r    <= dy_r[31];
    zero2_r <= (dx_r == 32'd0) && (dy_r == 32'd0);
  end

  // ---------------------------------------------------------------- octant select
  logic                      v3_r;
  logic [31:0]               num_sh_r;
  logic [pta_pkg::DEN_W-1:0] den_sh_r;
  logic                      small_r;
  pta_pkg::tag_t             tag3_r;

  logic          gt_w;
  logic [31:0]   num_w;
  logic [31:0]   den_w;
  pta_pkg::tag_t tag3_nxt;

  always_comb begin
    gt_w          = $signed(ax_r) > $signed(ay_r);
    num_w         = gt_w ? ay_r : ax_r;
    den_w         = gt_w ? ax_r : ay_r;
    tag3_nxt.zero = zero2_r;
    tag3_nxt.oct  = pta_pkg::octant_t'({xn_r, yn_r, gt_w});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    num_sh_r <= num_w << pta_pkg::NUM_SHIFT;
    den_sh_r <= den_w[31:pta_pkg::DEN_SHIFT];
    small_r  <= den_w < 32'(pta_pkg::SMALL_DEN);
    tag3_r   <= tag3_nxt;
  end

  // ---------------------------------------------------------------- slope divide
  logic             dv_valid;
  logic [AW-1:0]    dv_quo;
  logic             dv_sat;
  logic [TAG_W-1:0] dv_tag;

  pta_div #(
    .QB    (AW),
    .TAG_W (TAG_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v3_r),
    .in_num    (num_sh_r),
    .in_den    (den_sh_r),
    .in_force  (small_r),
    .in_tag    (tag3_r),
    .out_valid (dv_valid),
    .out_quo   (dv_quo),
    .out_sat   (dv_sat),
    .out_tag   (dv_tag)
  );

  // ---------------------------------------------------------------- table index
  logic          v4_r;
  logic [AW-1:0] idx_r;
  logic [AW-1:0] idx_nxt;
  pta_pkg::tag_t tag4_r;

  assign idx_nxt = (dv_sat || (dv_quo > AW'(SLOPE_STEPS))) ? AW'(SLOPE_STEPS) : dv_quo;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    tag4_r <= pta_pkg::tag_t'(dv_tag);
  end

  // ---------------------------------------------------------------- table read
  logic          v5_r;
  pta_pkg::tag_t tag5_r;
  logic [31:0]   rom_q;

  pta_ram #(
    .WIDTH (32),
    .DEPTH (SLOPE_STEPS + 1)
  ) u_atan_ram (
    .clk   (clk),
    .we    (fill_act_r),
    .waddr (fill_cnt_r),
    .wdata (rom_tbl[fill_cnt_r]),
    .raddr (idx_r),
    .rdata (rom_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    tag5_r <= tag4_r;
  end

  // ---------------------------------------------------------------- octant fixup
  logic        out_valid_r;
  logic [31:0] angle_r;
  logic [31:0] angle_nxt;

  // ~r stands for -1-r, so no octant needs more than one add or subtract
  always_comb begin
    case (tag5_r.oct)
      pta_pkg::OCT_ENE: angle_nxt = rom_q;
      pta_pkg::OCT_NNE: angle_nxt = pta_pkg::ANG_90 + ~rom_q;
      pta_pkg::OCT_NNW: angle_nxt = pta_pkg::ANG_90 + rom_q;
      pta_pkg::OCT_WNW: angle_nxt = pta_pkg::ANG_180 + ~rom_q;
      pta_pkg::OCT_WSW: angle_nxt = pta_pkg::ANG_180 + rom_q;
      pta_pkg::OCT_SSW: angle_nxt = pta_pkg::ANG_270 + ~rom_q;
      pta_pkg::OCT_SSE: angle_nxt = pta_pkg::ANG_270 + rom_q;
      pta_pkg::OCT_ESE: angle_nxt = 32'd0 - rom_q;
      default:          angle_nxt = rom_q;
    endcase
    if (tag5_r.zero) begin
      angle_nxt = 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    angle_r <= angle_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_angle = angle_r;

  // ---------------------------------------------------------------- checks
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> ##LAT out_valid)
    else $error("item did not come out after the pipeline latency");

  a_no_entry_in_load: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> !v1_r)
    else $error("item entered while the table was loading");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r |-> (idx_r <= AW'(SLOPE_STEPS)))
    else $error("table index beyond the last entry");

  a_load_complete: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(fill_act_r) |-> ($past(fill_cnt_r) == AW'(SLOPE_STEPS)))
    else $error("table load ended early");

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// testbench for point_to_angle_octant_atan: octant arctangent angle of a point seen from a view
// depends on pta_pkg (octant codes, angle constants) and the top level; self-checking
`timescale 1ns / 100ps

module tb;

  localparam int STEPS = 2048;
  localparam int RANDOM_QUERIES = 450;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] vx;
    logic [31:0] vy;
  } query_t;

  class angle_scoreboard;
    logic [31:0] atan_rom [0:STEPS];
    logic [31:0] angle_q [$];
    int mismatches;
    int points_seen;
    int angles_seen;
    int zero_hits;
    int octant_hits [8];

    function new();
      real half_turn;
      real v;
      half_turn = 4.0 * $atan(1.0);
      for (int i = 0; i <= STEPS; i++) begin
        v = $atan(real'(i) / real'(STEPS)) * 4294967296.0 / (2.0 * half_turn);
        atan_rom[i] = 32'(longint'($floor(v + 0.5)));
      end
    endfunction

    function int unsigned slope_index(logic [31:0] num, logic [31:0] den);
      logic [31:0] q;
      if (den < 32'd512) return STEPS;
      q = (num << 3) / (den >> 8);
      return (q > STEPS) ? STEPS : q;
    endfunction

    function logic [31:0] predict_angle(query_t q);
      logic [31:0]       dx;
      logic [31:0]       dy;
      logic [31:0]       mx;
      logic [31:0]       my;
      logic              x_wider;
      pta_pkg::octant_t  oct;
      dx = q.px - q.vx;
      dy = q.py - q.vy;
      if (dx == 0 && dy == 0) begin
        zero_hits++;
        return 32'd0;
      end
      // negation wraps, so -2^31 keeps its sign bit and loses the compare
      mx = dx[31] ? -dx : dx;
      my = dy[31] ? -dy : dy;
      x_wider = $signed(mx) > $signed(my);
      oct = pta_pkg::octant_t'({dx[31], dy[31], x_wider});
      octant_hits[oct]++;
      case (oct)
        pta_pkg::OCT_ENE: return atan_rom[slope_index(my, mx)];
        pta_pkg::OCT_NNE: return pta_pkg::ANG_90 - 32'd1 - atan_rom[slope_index(mx, my)];
        pta_pkg::OCT_ESE: return 32'd0 - atan_rom[slope_index(my, mx)];
        pta_pkg::OCT_SSE: return pta_pkg::ANG_270 + atan_rom[slope_index(mx, my)];
        pta_pkg::OCT_WNW: return pta_pkg::ANG_180 - 32'd1 - atan_rom[slope_index(my, mx)];
        pta_pkg::OCT_NNW: return pta_pkg::ANG_90 + atan_rom[slope_index(mx, my)];
        pta_pkg::OCT_WSW: return pta_pkg::ANG_180 + atan_rom[slope_index(my, mx)];
        default: return pta_pkg::ANG_270 - 32'd1 - atan_rom[slope_index(mx, my)];
      endcase
    endfunction

    function void note_point(query_t q);
      angle_q.push_back(predict_angle(q));
      points_seen++;
    endfunction

    task report_mismatch(string msg);
      if (mismatches < 20) $display("mismatch at %0t: %s", $time, msg);
      mismatches++;
    endtask

    task check_angle(logic [31:0] got);
      logic [31:0] want;
      angles_seen++;
      if (angle_q.size() == 0) begin
        report_mismatch($sformatf("angle %h with no item pending", got));
      end else begin
        want = angle_q.pop_front();
        if (got !== want)
          report_mismatch($sformatf("angle %h, expected %h", got, want));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic [31:0] in_point_x = '0;
  logic [31:0] in_point_y = '0;
  logic [31:0] in_view_x = '0;
  logic [31:0] in_view_y = '0;
  logic        busy;
  logic        out_valid;
  logic [31:0] out_angle;

  angle_scoreboard sb = new();

  point_to_angle_octant_atan #(
    .SLOPE_STEPS(STEPS)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_point_x (in_point_x),
    .in_point_y (in_point_y),
    .in_view_x  (in_view_x),
    .in_view_y  (in_view_y),
    .out_valid  (out_valid),
    .out_angle  (out_angle)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // inputs change only by nonblocking assignment, so these are the values the block sampled
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) sb.note_point('{in_point_x, in_point_y, in_view_x, in_view_y});
      if (out_valid) sb.check_angle(out_angle);
    end
  end

  function automatic query_t mk_query(logic [31:0] px, logic [31:0] py,
                                      logic [31:0] vx, logic [31:0] vy);
    return '{px, py, vx, vy};
  endfunction

  // random magnitude below 2^k with random sign
  function automatic logic [31:0] rand_offset(int k);
    logic [31:0] r;
    r = $urandom;
    if (k == 0) r = '0;
    else if (k < 32) r = r & ((32'h1 << k) - 32'h1);
    if ($urandom_range(0, 1)) r = -r;
    return r;
  endfunction

  function automatic query_t random_query();
    query_t      q;
    logic [31:0] dx;
    logic [31:0] dy;
    logic [31:0] t;
    q = {$urandom, $urandom, $urandom, $urandom};
    case ($urandom_range(0, 9))
      0, 1, 2: return q;
      3, 4, 5: begin
        dx = rand_offset($urandom_range(0, 24));
        dy = rand_offset($urandom_range(0, 24));
      end
      6: begin
        // on an axis or a diagonal
        dx = rand_offset($urandom_range(1, 30));
        case ($urandom_range(0, 2))
          0: dy = '0;
          1: dy = dx;
          default: dy = -dx;
        endcase
        if ($urandom_range(0, 1)) begin
          t = dx;
          dx = dy;
          dy = t;
        end
      end
      7: begin
        dx = ($urandom_range(0, 3) == 0) ? 32'h8000_0000 : rand_offset(32);
        dy = rand_offset($urandom_range(28, 32));
      end
      8: begin
        // short offsets, below 2^11, where the divisor can fall under the small limit
        dx = rand_offset($urandom_range(0, 11));
        dy = rand_offset($urandom_range(0, 11));
      end
      default: begin
        dx = rand_offset($urandom_range(0, 32));
        dy = rand_offset($urandom_range(0, 32));
      end
    endcase
    q.px = q.vx + dx;
    q.py = q.vy + dy;
    return q;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(15, 60);
  endfunction

  task automatic idle(int n);
    if (n == 0) return;
    start <= 1'b0;
    in_point_x <= $urandom;
    in_point_y <= $urandom;
    in_view_x <= $urandom;
    in_view_y <= $urandom;
    repeat (n) @(posedge clk);
  endtask

  task automatic send_point(query_t q);
    start <= 1'b1;
    in_point_x <= q.px;
    in_point_y <= q.py;
    in_view_x <= q.vx;
    in_view_y <= q.vy;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  initial begin
    query_t directed [$];
    bit     steady;
    int     guard;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed.push_back(mk_query(32'h0001_2345, 32'hFFFE_0000, 32'h0001_2345, 32'hFFFE_0000));
    directed.push_back(mk_query(32'd0, 32'd0, 32'd0, 32'd0));
    directed.push_back(mk_query(32'd1, 32'd0, 32'd0, 32'd0));
    directed.push_back(mk_query(32'd0, 32'd1, 32'd0, 32'd0));
    directed.push_back(mk_query(32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0));
    directed.push_back(mk_query(32'd0, 32'hFFFF_FFFF, 32'd0, 32'd0));
    // one point in each octant
    directed.push_back(mk_query(32'h0003_0000, 32'h0001_0000, 32'd0, 32'd0));
    directed.push_back(mk_query(32'h0001_0000, 32'h0003_0000, 32'd0, 32'd0));
    directed.push_back(mk_query(-32'h0001_0000, 32'h0003_0000, 32'd0, 32'd0));
    directed.push_back(mk_query(-32'h0003_0000, 32'h0001_0000, 32'd0, 32'd0));
    directed.push_back(mk_query(-32'h0003_0000, -32'h0001_0000, 32'd0, 32'd0));
    directed.push_back(mk_query(-32'h0001_0000, -32'h0003_0000, 32'd0, 32'd0));
    directed.push_back(mk_query(32'h0001_0000, -32'h0003_0000, 32'd0, 32'd0));
    directed.push_back(mk_query(32'h0003_0000, -32'h0001_0000, 32'd0, 32'd0));
    // diagonals, divisor under and at the small limit, saturated slope
    directed.push_back(mk_query(32'h0010_0000, 32'h0010_0000, 32'd0, 32'd0));
    directed.push_back(mk_query(-32'h0010_0000, -32'h0010_0000, 32'd0, 32'd0));
    directed.push_back(mk_query(32'd100, 32'd50, 32'd0, 32'd0));
    directed.push_back(mk_query(32'd512, 32'd3, 32'd0, 32'd0));
    directed.push_back(mk_query(32'd767, 32'd767, 32'd0, 32'd0));
    // most negative offsets and wrapping differences
    directed.push_back(mk_query(32'h8000_0000, 32'd5, 32'd0, 32'd0));
    directed.push_back(mk_query(32'h8000_0000, 32'h8000_0000, 32'd0, 32'd0));
    directed.push_back(mk_query(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000));
    directed.push_back(mk_query(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    directed.push_back(mk_query(32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'd0));
    directed.push_back(mk_query(32'h7000_0000, 32'h6000_0000, 32'd0, 32'd0));
    directed.push_back(mk_query(32'h7FFF_FFFF, 32'h4000_0000, 32'd0, 32'd0));

    foreach (directed[i]) begin
      idle($urandom_range(0, 2));
      send_point(directed[i]);
    end

    steady = 1'b0;
    for (int n = 0; n < RANDOM_QUERIES; n++) begin
      if (n % 50 == 0) steady = ($urandom_range(0, 3) == 0);
      if (n == RANDOM_QUERIES / 2) begin
        // let the pipeline run dry before going on
        start <= 1'b0;
        do @(posedge clk); while (sb.angle_q.size() != 0);
      end
      if (!steady) idle(gap_len());
      send_point(random_query());
    end
    start <= 1'b0;

    guard = 0;
    while (sb.angle_q.size() != 0 && guard < 1000) begin
      @(posedge clk);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.angle_q.size() != 0)
      sb.report_mismatch($sformatf("%0d angles never arrived", sb.angle_q.size()));

    $display("sent %0d items (%0d directed), checked %0d angles, %0d zero offsets",
             sb.points_seen, directed.size(), sb.angles_seen, sb.zero_hits);
    $display("octant hits nne %0d ene %0d sse %0d ese %0d nnw %0d wnw %0d ssw %0d wsw %0d",
             sb.octant_hits[0], sb.octant_hits[1], sb.octant_hits[2], sb.octant_hits[3],
             sb.octant_hits[4], sb.octant_hits[5], sb.octant_hits[6], sb.octant_hits[7]);
    if (sb.mismatches == 0) begin
      $display("[point_to_angle_octant_atan] OK");
    end else begin
      $display("[point_to_angle_octant_atan] ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[point_to_angle_octant_atan] ERROR");
    $finish;
  end

endmodule

// ===== point_to_angle_octant_atan.f =====
hw/rtl/pta_pkg.sv
hw/rtl/pta_ram.sv
hw/rtl/pta_div.sv
hw/rtl/point_to_angle_octant_atan.sv
sim/tb.sv
